// ===== hdl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int CRC_W           = 16;
	localparam int LEN_W           = 7;
	localparam int IDX_OUT_W       = 6;
	localparam int STATUS_W        = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int HDR_BYTES       = 3;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'h7e;
	localparam logic [CRC_W-1:0]  CRC_INIT_RESET = 16'hffff;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;

	localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CRC = 2'd2;

	localparam logic [1:0] HCNT_SENDER = 2'd0;
	localparam logic [1:0] HCNT_TYPE   = 2'd1;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_HDR,
		ST_PAY,
		ST_CRC,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_byte;
		logic [CRC_W-1:0]  crc_init;
	} cfg_t;

	// CRC-16-CCITT, MSB first, one byte
	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sfr_ram.sv =====
`default_nettype none

module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/sfr_ctrl.sv =====
`default_nettype none

module sfr_ctrl #(
	parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	localparam int IW = $clog2(MAX_PAYLOAD + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sfr_pkg::cfg_t                     cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [sfr_pkg::BYTE_W-1:0]        rx_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [sfr_pkg::STATUS_W-1:0]      status,
	output logic      [sfr_pkg::BYTE_W-1:0]        sender_id,
	output logic      [sfr_pkg::BYTE_W-1:0]        msg_type,
	output logic      [sfr_pkg::BYTE_W-1:0]        payload_len,
	output logic      [sfr_pkg::IDX_OUT_W-1:0]     byte_index,
	output logic      [sfr_pkg::BYTE_W-1:0]        payload_byte,
	output logic                                   last,
	output logic                                   ram_we,
	output logic      [AW-1:0]                     ram_waddr,
	output logic      [sfr_pkg::BYTE_W-1:0]        ram_wdata,
	output logic      [AW-1:0]                     ram_raddr,
	input  wire logic [sfr_pkg::BYTE_W-1:0]        ram_rdata
);

	sfr_pkg::state_t state_q, state_d;

	logic [1:0]                      hcnt_q, hcnt_d;
	logic [sfr_pkg::BYTE_W-1:0]      sender_q, sender_d;
	logic [sfr_pkg::BYTE_W-1:0]      type_q, type_d;
	logic [sfr_pkg::LEN_W-1:0]       len_q, len_d;
	logic [IW-1:0]                   idx_q, idx_d, idx_inc;
	logic [sfr_pkg::CRC_W-1:0]       crc_q, crc_d, crc_next;
	logic [sfr_pkg::BYTE_W-1:0]      crc_hi_q, crc_hi_d;
	logic                            crc_hi_seen_q, crc_hi_seen_d;

	logic                            ov_q, ov_d;
	logic [sfr_pkg::STATUS_W-1:0]    ostat_q, ostat_d;
	logic [sfr_pkg::BYTE_W-1:0]      olen_q, olen_d;
	logic [sfr_pkg::IDX_OUT_W-1:0]   oidx_q, oidx_d;
	logic [sfr_pkg::BYTE_W-1:0]      obyte_q, obyte_d;
	logic                            olast_q, olast_d;

	logic in_acc, out_free, parsing, len_bad, at_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sfr_pkg::ST_HUNT;
			hcnt_q        <= sfr_pkg::HCNT_SENDER;
			sender_q      <= '0;
			type_q        <= '0;
			len_q         <= '0;
			idx_q         <= '0;
			crc_q         <= sfr_pkg::CRC_INIT_RESET;
			crc_hi_q      <= '0;
			crc_hi_seen_q <= 1'b0;
			ov_q          <= 1'b0;
		end else begin
			state_q       <= state_d;
			hcnt_q        <= hcnt_d;
			sender_q      <= sender_d;
			type_q        <= type_d;
			len_q         <= len_d;
			idx_q         <= idx_d;
			crc_q         <= crc_d;
			crc_hi_q      <= crc_hi_d;
			crc_hi_seen_q <= crc_hi_seen_d;
			ov_q          <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		ostat_q <= ostat_d;
		olen_q  <= olen_d;
		oidx_q  <= oidx_d;
		obyte_q <= obyte_d;
		olast_q <= olast_d;
	end

	assign out_free = !ov_q || out_ready;
	assign parsing  = (state_q == sfr_pkg::ST_HUNT) || (state_q == sfr_pkg::ST_HDR) ||
		(state_q == sfr_pkg::ST_PAY) || (state_q == sfr_pkg::ST_CRC);
	assign in_ready = parsing && out_free;
	assign in_acc   = in_valid && in_ready;
	assign crc_next = sfr_pkg::crc_step(crc_q, rx_byte);
	assign idx_inc  = idx_q + 1'b1;
	assign at_len   = (8'(idx_inc) == 8'(len_q));
	assign len_bad  = (rx_byte == '0) || (rx_byte > 8'(MAX_PAYLOAD));

	always_comb begin
		state_d       = state_q;
		hcnt_d        = hcnt_q;
		sender_d      = sender_q;
		type_d        = type_q;
		len_d         = len_q;
		idx_d         = idx_q;
		crc_d         = crc_q;
		crc_hi_d      = crc_hi_q;
		crc_hi_seen_d = crc_hi_seen_q;
		ov_d          = ov_q && !out_ready;
		ostat_d       = ostat_q;
		olen_d        = olen_q;
		oidx_d        = oidx_q;
		obyte_d       = obyte_q;
		olast_d       = olast_q;
		ram_we        = 1'b0;
		ram_raddr     = idx_q[AW-1:0];

		unique case (state_q)
			sfr_pkg::ST_HUNT: begin
				if (in_acc && rx_byte == cfg.sync_byte) begin
					state_d = sfr_pkg::ST_HDR;
					hcnt_d  = sfr_pkg::HCNT_SENDER;
					crc_d   = cfg.crc_init;
				end
			end
			sfr_pkg::ST_HDR: begin
				if (in_acc) begin
					crc_d = crc_next;
					case (hcnt_q)
						sfr_pkg::HCNT_SENDER: begin
							sender_d = rx_byte;
							hcnt_d   = sfr_pkg::HCNT_TYPE;
						end
						sfr_pkg::HCNT_TYPE: begin
							type_d = rx_byte;
							hcnt_d = 2'(sfr_pkg::HCNT_TYPE + 1'b1);
						end
						default: begin
							hcnt_d = sfr_pkg::HCNT_SENDER;
							len_d  = rx_byte[sfr_pkg::LEN_W-1:0];
							idx_d  = '0;
							if (len_bad) begin
								state_d = sfr_pkg::ST_HUNT;
								ov_d    = 1'b1;
								ostat_d = sfr_pkg::STATUS_BAD_LEN;
								olen_d  = rx_byte;
								oidx_d  = '0;
								obyte_d = '0;
								olast_d = 1'b1;
							end else begin
								state_d = sfr_pkg::ST_PAY;
							end
						end
					endcase
				end
			end
			sfr_pkg::ST_PAY: begin
				if (in_acc) begin
					ram_we = 1'b1;
					crc_d  = crc_next;
					idx_d  = idx_inc;
					if (at_len) begin
						state_d       = sfr_pkg::ST_CRC;
						crc_hi_seen_d = 1'b0;
					end
				end
			end
			sfr_pkg::ST_CRC: begin
				if (in_acc) begin
					if (!crc_hi_seen_q) begin
						crc_hi_d      = rx_byte;
						crc_hi_seen_d = 1'b1;
					end else if ({crc_hi_q, rx_byte} != crc_q) begin
						state_d = sfr_pkg::ST_HUNT;
						ov_d    = 1'b1;
						ostat_d = sfr_pkg::STATUS_BAD_CRC;
						olen_d  = 8'(len_q);
						oidx_d  = '0;
						obyte_d = '0;
						olast_d = 1'b1;
					end else begin
						state_d = sfr_pkg::ST_RD_ADDR;
						idx_d   = '0;
					end
				end
			end
			sfr_pkg::ST_RD_ADDR: begin
				state_d = sfr_pkg::ST_RD_OUT;
			end
			sfr_pkg::ST_RD_OUT: begin
				// read data belongs to idx_q; prefetch the next entry on load
				if (out_free) begin
					ov_d      = 1'b1;
					ostat_d   = sfr_pkg::STATUS_GOOD;
					olen_d    = 8'(len_q);
					oidx_d    = 6'(idx_q);
					obyte_d   = ram_rdata;
					olast_d   = at_len;
					idx_d     = idx_inc;
					ram_raddr = idx_inc[AW-1:0];
					if (at_len) begin
						state_d = sfr_pkg::ST_HUNT;
					end
				end
			end
			default: begin
				state_d = sfr_pkg::ST_HUNT;
			end
		endcase
	end

	assign ram_waddr    = idx_q[AW-1:0];
	assign ram_wdata    = rx_byte;
	assign out_valid    = ov_q;
	assign status       = ostat_q;
	assign sender_id    = sender_q;
	assign msg_type     = type_q;
	assign payload_len  = olen_q;
	assign byte_index   = oidx_q;
	assign payload_byte = obyte_q;
	assign last         = olast_q;

endmodule

`default_nettype wire

// ===== hdl/sync_frame_receiver_crc16.sv =====
// Framed byte receiver with CRC-16-CCITT check.
// Input channel: in_valid/in_ready/rx_byte, one received byte per beat. The
// block hunts for the sync byte, takes sender, type and length header bytes,
// stores the payload in a single-port-write RAM and checks the two big-endian
// CRC bytes (poly 0x1021, MSB first, seeded from crc_init at each sync byte).
// Output channel: out_valid/out_ready plus the result fields, one result per
// beat. A good frame gives one beat per payload byte, last marking the final
// one; a bad length or a CRC mismatch gives a single beat with last set.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready.
// Index 0 is sync_byte, index 1 is crc_init, other indexes are dropped.
// Throughput: one input byte per cycle while parsing a frame and the output
// is not stalled. After the last CRC byte of a good frame, input is held off
// while the RAM is read out: the ST_RD_ADDR state starts the first read, then
// one result per cycle unless the output stalls, bounded by the RAM read port.
// An error result is valid the cycle after the byte that caused it; the first
// payload result is loaded in ST_RD_OUT, after ST_RD_ADDR.
// A stalled receiver holds the output register; input is then refused until
// the pending result is taken. Reset returns to hunting with registers at
// sync 0x7e and crc_init 0xffff; payload RAM contents are not cleared.
`default_nettype none

module sync_frame_receiver_crc16 #(
	parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [sfr_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [sfr_pkg::STATUS_W-1:0]       status,
	output logic      [sfr_pkg::BYTE_W-1:0]         sender_id,
	output logic      [sfr_pkg::BYTE_W-1:0]         msg_type,
	output logic      [sfr_pkg::BYTE_W-1:0]         payload_len,
	output logic      [sfr_pkg::IDX_OUT_W-1:0]      byte_index,
	output logic      [sfr_pkg::BYTE_W-1:0]         payload_byte,
	output logic                                    last,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	sfr_pkg::cfg_t                cfg_q;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [sfr_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte <= sfr_pkg::SYNC_RESET;
			cfg_q.crc_init  <= sfr_pkg::CRC_INIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfr_pkg::REG_SYNC:     cfg_q.sync_byte <= cfg_data[sfr_pkg::BYTE_W-1:0];
				sfr_pkg::REG_CRC_INIT: cfg_q.crc_init  <= cfg_data[sfr_pkg::CRC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sfr_ctrl #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.sender_id   (sender_id),
		.msg_type    (msg_type),
		.payload_len (payload_len),
		.byte_index  (byte_index),
		.payload_byte(payload_byte),
		.last        (last),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	sfr_ram #(
		.WIDTH(sfr_pkg::BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

// ===== hdl/sfr_chk.sv =====
`default_nettype none

module sfr_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [sfr_pkg::STATUS_W-1:0]      status,
	input wire logic [sfr_pkg::IDX_OUT_W-1:0]     byte_index,
	input wire logic [sfr_pkg::BYTE_W-1:0]        payload_byte,
	input wire logic                              last
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(byte_index) && $stable(payload_byte) && $stable(last))
		else $error("output beat changed while stalled");

	// error beats are single, last and zero filled
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != sfr_pkg::STATUS_GOOD |->
		last && byte_index == '0 && payload_byte == '0)
		else $error("malformed error beat");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == sfr_pkg::STATUS_GOOD ||
		status == sfr_pkg::STATUS_BAD_LEN || status == sfr_pkg::STATUS_BAD_CRC)
		else $error("undefined status code");

	// input is held off during payload readout
	a_readout_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sfr_pkg::STATUS_GOOD && !last |-> !in_ready)
		else $error("input taken during readout");

	// next payload beat follows in order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status == sfr_pkg::STATUS_GOOD && !last
		##1 out_valid |-> status == sfr_pkg::STATUS_GOOD &&
		byte_index == 6'($past(byte_index) + 1'b1))
		else $error("payload index out of sequence");

endmodule

bind sync_frame_receiver_crc16 sfr_chk u_sfr_chk (.*);

`default_nettype wire

// ===== tb/tb_sync_frame_receiver_crc16.sv =====
`timescale 1ns / 100ps

module tb_sync_frame_receiver_crc16;

	localparam int MAX_PAY        = sfr_pkg::MAX_PAYLOAD_DEF;
	localparam int FRAME_ITEMS    = 300;
	localparam int NUM_SETTINGS   = 6;
	localparam int SETTLE_CYCLES  = 4;

	localparam logic [1:0] HCNT_LENGTH = 2'd2;
	localparam logic [6:0] FCS_BYTES   = 7'd2;

	// indexes with no register behind them
	localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

	typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_FCS} rx_phase_t;

	typedef struct {
		logic [1:0] status;
		logic [7:0] sender;
		logic [7:0] kind;
		logic [7:0] plen;
		logic [5:0] idx;
		logic [7:0] value;
		logic       last;
	} frame_result_t;

	// CRC-16-CCITT, bit-serial form, MSB first
	function automatic logic [15:0] ccitt_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ sfr_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	class rx_frame_model;
		logic [7:0]    sync_val;
		logic [15:0]   seed;
		rx_phase_t     ph;
		logic [1:0]    hcount;
		logic [7:0]    sender;
		logic [7:0]    kind;
		logic [6:0]    hlen;
		logic [6:0]    left;
		logic [15:0]   crc;
		logic [7:0]    crc_hi;
		logic [7:0]    store [MAX_PAY];
		frame_result_t due [$];
		int            errors;
		int            n_good;
		int            n_badlen;
		int            n_badcrc;

		function new();
			sync_val = sfr_pkg::SYNC_RESET;
			seed     = sfr_pkg::CRC_INIT_RESET;
			ph       = PH_HUNT;
			hcount   = sfr_pkg::HCNT_SENDER;
			sender   = '0;
			kind     = '0;
			hlen     = '0;
			left     = '0;
			crc      = seed;
			crc_hi   = '0;
			foreach (store[i]) store[i] = '0;
			errors   = 0;
			n_good   = 0;
			n_badlen = 0;
			n_badcrc = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				sfr_pkg::REG_SYNC:     sync_val = data[7:0];
				sfr_pkg::REG_CRC_INIT: seed = data;
				default: ;
			endcase
		endfunction

		function void push(logic [1:0] st, logic [7:0] plen, logic [5:0] idx,
			logic [7:0] v, logic lst);
			frame_result_t r;
			r.status = st;
			r.sender = sender;
			r.kind   = kind;
			r.plen   = plen;
			r.idx    = idx;
			r.value  = v;
			r.last   = lst;
			due.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b);
			logic [6:0]  pos;
			logic [15:0] rx;
			case (ph)
				PH_HUNT: begin
					if (b == sync_val) begin
						ph     = PH_HEADER;
						hcount = sfr_pkg::HCNT_SENDER;
						crc    = seed;
					end
				end
				PH_HEADER: begin
					crc = ccitt_byte(crc, b);
					if (hcount == sfr_pkg::HCNT_SENDER) begin
						sender = b;
						hcount = sfr_pkg::HCNT_TYPE;
					end else if (hcount == sfr_pkg::HCNT_TYPE) begin
						kind   = b;
						hcount = HCNT_LENGTH;
					end else begin
						hcount = sfr_pkg::HCNT_SENDER;
						hlen   = b[6:0];
						if (int'(b) == 0 || int'(b) > MAX_PAY) begin
							ph = PH_HUNT;
							push(sfr_pkg::STATUS_BAD_LEN, b, '0, '0, 1'b1);
						end else begin
							left = b[6:0];
							ph   = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pos = hlen - left;
					if (int'(pos) < MAX_PAY) begin
						store[pos] = b;
					end
					crc  = ccitt_byte(crc, b);
					left = left - 7'd1;
					if (left == '0) begin
						ph   = PH_FCS;
						left = FCS_BYTES;
					end
				end
				default: begin
					if (left == FCS_BYTES) begin
						crc_hi = b;
						left   = FCS_BYTES - 7'd1;
					end else begin
						ph   = PH_HUNT;
						left = '0;
						rx   = {crc_hi, b};
						if (rx != crc) begin
							push(sfr_pkg::STATUS_BAD_CRC, {1'b0, hlen}, '0, '0, 1'b1);
						end else begin
							for (int k = 0; k < int'(hlen) && k < MAX_PAY; k++) begin
								push(sfr_pkg::STATUS_GOOD, {1'b0, hlen}, 6'(k), store[k],
									k + 1 == int'(hlen));
							end
						end
					end
				end
			endcase
		endfunction

		function void match_result(frame_result_t got);
			frame_result_t want;
			if (due.size() == 0) begin
				$error("result beat with nothing due: status %0d sender_id %0h byte_index %0d",
					got.status, got.sender, got.idx);
				errors++;
				return;
			end
			want = due.pop_front();
			case (want.status)
				sfr_pkg::STATUS_GOOD:    n_good++;
				sfr_pkg::STATUS_BAD_LEN: n_badlen++;
				default:                 n_badcrc++;
			endcase
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.sender !== want.sender) begin
				$error("sender_id: expected %0h, got %0h", want.sender, got.sender);
				errors++;
			end
			if (got.kind !== want.kind) begin
				$error("msg_type: expected %0h, got %0h", want.kind, got.kind);
				errors++;
			end
			if (got.plen !== want.plen) begin
				$error("payload_len: expected %0d, got %0d", want.plen, got.plen);
				errors++;
			end
			if (got.idx !== want.idx) begin
				$error("byte_index: expected %0d, got %0d", want.idx, got.idx);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("payload_byte: expected %0h, got %0h", want.value, got.value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	logic        in_ready;
	logic        out_valid;
	logic [1:0]  status;
	logic [7:0]  sender_id;
	logic [7:0]  msg_type;
	logic [7:0]  payload_len;
	logic [5:0]  byte_index;
	logic [7:0]  payload_byte;
	logic        last;
	logic        cfg_ready;

	rx_frame_model rxm = new();
	logic [7:0]    frame_q [$];
	bit            quiet = 1'b0;
	int            n_sent = 0;
	int            n_items = 0;
	int            n_writes = 0;

	sync_frame_receiver_crc16 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.sender_id    (sender_id),
		.msg_type     (msg_type),
		.payload_len  (payload_len),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.sender = sender_id;
			got.kind   = msg_type;
			got.plen   = payload_len;
			got.idx    = byte_index;
			got.value  = payload_byte;
			got.last   = last;
			rxm.match_result(got);
		end
	end

	// result side back-pressure: long ready runs, short stalls, rare long stalls
	initial begin
		int n;
		forever begin
			@(posedge clk);
			n = $urandom_range(0, 99);
			if (n < 65) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 29)) @(posedge clk);
			end else if (n < 95) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 30)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 6);
		end else if (r < 95) begin
			return $urandom_range(7, 20);
		end
		return $urandom_range(21, MAX_PAY);
	endfunction

	// sync, header, payload and FCS built with the settings the block will use;
	// flip corrupts the FCS, a bad length stops after the header
	function automatic void make_frame(input logic [7:0] lenb, input logic [15:0] flip);
		logic [15:0] c;
		logic [7:0]  s;
		logic [7:0]  t;
		logic [7:0]  v;
		frame_q.delete();
		s = 8'($urandom);
		t = 8'($urandom);
		c = rxm.seed;
		frame_q.push_back(rxm.sync_val);
		frame_q.push_back(s);
		frame_q.push_back(t);
		frame_q.push_back(lenb);
		c = ccitt_byte(c, s);
		c = ccitt_byte(c, t);
		c = ccitt_byte(c, lenb);
		if (int'(lenb) == 0 || int'(lenb) > MAX_PAY) begin
			return;
		end
		for (int i = 0; i < int'(lenb); i++) begin
			v = ($urandom_range(0, 15) == 0) ? rxm.sync_val : 8'($urandom);
			frame_q.push_back(v);
			c = ccitt_byte(c, v);
		end
		c = c ^ flip;
		frame_q.push_back(c[15:8]);
		frame_q.push_back(c[7:0]);
	endfunction

	task automatic send_byte(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		rxm.take_byte(b);
		n_sent++;
		n_items++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) begin
			send_byte(frame_q[i], pick_gap());
		end
	endtask

	task automatic await_idle();
		in_valid <= 1'b0;
		while (rxm.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		in_valid  <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		rxm.set_reg(idx, data);
		n_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_traffic();
		int         r;
		int         n;
		logic [7:0] b;
		r     = $urandom_range(0, 99);
		quiet = ($urandom_range(0, 5) == 0);
		if (r < 10) begin
			// line noise while hunting
			n = $urandom_range(1, 4);
			repeat (n) begin
				b = 8'($urandom);
				if (b == rxm.sync_val) begin
					b = ~b;
				end
				send_byte(b, pick_gap());
			end
		end else if (r < 18) begin
			b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(MAX_PAY + 1, 255));
			make_frame(b, '0);
			send_frame();
		end else if (r < 28) begin
			make_frame(8'(pick_len()), 16'($urandom_range(1, 65535)));
			send_frame();
		end else if (r < 32) begin
			// sync followed by junk
			frame_q.delete();
			frame_q.push_back(rxm.sync_val);
			repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
			send_frame();
		end else begin
			make_frame(8'(pick_len()), '0);
			send_frame();
		end
		if ($urandom_range(0, 9) == 0) begin
			await_idle();
		end
	endtask

	initial begin
		logic [7:0]  sync_set [NUM_SETTINGS];
		logic [15:0] init_set [NUM_SETTINGS];
		sync_set[0] = 8'h00;  init_set[0] = 16'h0000;
		sync_set[1] = 8'hff;  init_set[1] = 16'hffff;
		sync_set[2] = sfr_pkg::SYNC_RESET; init_set[2] = 16'h1d0f;
		sync_set[3] = 8'($urandom); init_set[3] = 16'($urandom);
		sync_set[4] = 8'hff;  init_set[4] = 16'h0000;
		sync_set[5] = 8'($urandom); init_set[5] = 16'($urandom);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: noise, shortest frame, bad lengths, FCS mismatch
		send_byte(8'h00, 0);
		send_byte(8'hff, 0);
		make_frame(8'd1, '0);
		send_frame();
		make_frame(8'd0, '0);
		send_frame();
		make_frame(8'(MAX_PAY + 1), '0);
		send_frame();
		make_frame(8'hff, '0);
		send_frame();
		make_frame(8'd2, 16'h0001);
		send_frame();

		// registers rewritten inside a frame must not touch it
		await_idle();
		make_frame(8'd3, '0);
		for (int i = 0; i < 4; i++) send_byte(frame_q[i], 0);
		write_reg(sfr_pkg::REG_SYNC, 16'h00a5);
		write_reg(sfr_pkg::REG_CRC_INIT, 16'h5a5a);
		for (int i = 4; i < frame_q.size(); i++) send_byte(frame_q[i], 0);
		await_idle();
		write_reg(REG_UNMAPPED_A, 16'hffff);
		write_reg(REG_UNMAPPED_B, 16'h0000);
		make_frame(8'd1, '0);
		send_frame();
		n_items = 0;

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			await_idle();
			write_reg(sfr_pkg::REG_SYNC, {8'h00, sync_set[p]});
			write_reg(sfr_pkg::REG_CRC_INIT, init_set[p]);
			if (p == 0) begin
				make_frame(8'(MAX_PAY), '0);
				send_frame();
			end
			while (n_items < (p + 1) * FRAME_ITEMS / NUM_SETTINGS) random_traffic();
		end

		await_idle();
		repeat (16) @(posedge clk);
		$display("%0d bytes sent over %0d settings, %0d register writes",
			n_sent, NUM_SETTINGS + 2, n_writes);
		$display("beats checked: %0d payload, %0d bad length, %0d FCS mismatch",
			rxm.n_good, rxm.n_badlen, rxm.n_badcrc);
		if (rxm.errors == 0 && rxm.due.size() == 0) begin
			$display("tb_sync_frame_receiver_crc16: clean");
		end else begin
			$display("tb_sync_frame_receiver_crc16: errors");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d beats still due", rxm.due.size());
		$display("tb_sync_frame_receiver_crc16: errors");
		$finish;
	end

endmodule

// ===== sync_frame_receiver_crc16.f =====
hdl/sfr_pkg.sv
hdl/sfr_ram.sv
hdl/sfr_ctrl.sv
hdl/sync_frame_receiver_crc16.sv
hdl/sfr_chk.sv
tb/tb_sync_frame_receiver_crc16.sv
